// File: hdl/cbf_pkg.sv
// Shared constants and controller/datapath signal groups for the cell balance flag engine.
`default_nettype none

package cbf_pkg;

    // Pack geometry
    localparam int CELL_ROWS = 16;
    localparam int CELL_COLS = 8;

    localparam int ROW_W  = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
    localparam int COL_W  = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;
    localparam int VOLT_W = 16;

    // Threshold after reset, millivolts
    localparam logic [VOLT_W-1:0] THRESHOLD_RESET = 16'd50;

    // Commands from controller to datapath
    typedef struct packed {
        logic cell_wr;   // cell beat accepted: store and update minimum
        logic rd_en;     // read the current emit row from the cell store
        logic out_load;  // capture flags of the row just read
        logic out_adv;   // result beat accepted: step to next row
    } cbf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_cell; // load position is the final cell of the pack
        logic last_emit; // emit row is the final row of the pack
    } cbf_status_t;

endpackage

`default_nettype wire

// File: hdl/cbf_if.sv
// Valid/ready channel interfaces for cell input, row results and configuration.
`default_nettype none

interface cbf_cell_if;
    logic                          valid;
    logic                          ready;
    logic [cbf_pkg::VOLT_W-1:0]    cell_voltage_mv;

    modport source (output valid, output cell_voltage_mv, input ready);
    modport sink   (input valid, input cell_voltage_mv, output ready);
endinterface

interface cbf_row_if;
    logic                          valid;
    logic                          ready;
    logic [3:0]                    row_index;
    logic [7:0]                    discharge_flags;
    logic [7:0]                    phase_a_flags;
    logic [7:0]                    phase_b_flags;
    logic [cbf_pkg::VOLT_W-1:0]    min_voltage_mv;
    logic [3:0]                    min_row;
    logic [2:0]                    min_col;
    logic                          last_row;

    modport source (output valid, output row_index, output discharge_flags,
                    output phase_a_flags, output phase_b_flags, output min_voltage_mv,
                    output min_row, output min_col, output last_row, input ready);
    modport sink   (input valid, input row_index, input discharge_flags,
                    input phase_a_flags, input phase_b_flags, input min_voltage_mv,
                    input min_row, input min_col, input last_row, output ready);
endinterface

interface cbf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cbf_pkg::VOLT_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cbf_ctrl.sv
// Controller state machine: collects cells, then sequences row reads and result beats.
`default_nettype none

module cbf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire cbf_pkg::cbf_status_t  status,
    output cbf_pkg::cbf_cmd_t          cmd
);

    typedef enum logic [1:0] {
        S_COLLECT,
        S_READ,
        S_CALC,
        S_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    logic in_beat;
    logic out_beat;

    assign in_beat  = in_valid && in_ready_reg;
    assign out_beat = out_valid_reg && out_ready;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // Commands decoded from state and handshakes
    always_comb
    begin
        cmd.cell_wr  = in_beat;
        cmd.rd_en    = (state_reg == S_READ);
        cmd.out_load = (state_reg == S_CALC);
        cmd.out_adv  = out_beat;
    end

    // Next state and registered handshake outputs
    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (in_beat && status.last_cell)
                begin
                    state_next    = S_READ;
                    in_ready_next = 1'b0;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next     = S_SEND;
                out_valid_next = 1'b1;
            end
            S_SEND:
            begin
                if (out_beat)
                begin
                    out_valid_next = 1'b0;
                    if (status.last_emit)
                    begin
                        state_next    = S_COLLECT;
                        in_ready_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next     = S_COLLECT;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and output sides are never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready_reg && out_valid_reg))
        else $error("cbf_ctrl: input ready while a result is pending");

    // Final row beat reopens collection
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && status.last_emit) |=> (in_ready_reg && (state_reg == S_COLLECT)))
        else $error("cbf_ctrl: collection not resumed after last row");

    // Last cell of a pack starts a row read
    a_start_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && status.last_cell) |=> (state_reg == S_READ))
        else $error("cbf_ctrl: emission not started after last cell");

endmodule

`default_nettype wire

// File: hdl/cbf_datapath.sv
// Datapath: cell store, running minimum, threshold register and row result register.
`default_nettype none

module cbf_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cbf_pkg::cbf_cmd_t             cmd,
    output cbf_pkg::cbf_status_t               status,
    input  wire logic                          cfg_wr,
    input  wire logic [cbf_pkg::VOLT_W-1:0]    cfg_data,
    input  wire logic [cbf_pkg::VOLT_W-1:0]    cell_voltage_mv,
    output logic [3:0]                         row_index,
    output logic [7:0]                         discharge_flags,
    output logic [7:0]                         phase_a_flags,
    output logic [7:0]                         phase_b_flags,
    output logic [cbf_pkg::VOLT_W-1:0]         min_voltage_mv,
    output logic [3:0]                         min_row,
    output logic [2:0]                         min_col,
    output logic                               last_row
);

    localparam int ROWS  = cbf_pkg::CELL_ROWS;
    localparam int COLS  = cbf_pkg::CELL_COLS;
    localparam int ROW_W = cbf_pkg::ROW_W;
    localparam int COL_W = cbf_pkg::COL_W;
    localparam int VW    = cbf_pkg::VOLT_W;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    // Cell store: one row-wide word per pack row, written one lane at a time
    logic [COLS-1:0][VW-1:0] cell_mem [ROWS];
    logic [COLS-1:0][VW-1:0] rd_data_reg;

    logic [VW-1:0]    thr_reg;
    logic [VW-1:0]    min_reg;
    logic [ROW_W-1:0] min_row_reg;
    logic [COL_W-1:0] min_col_reg;
    logic [ROW_W-1:0] ld_row_reg;
    logic [COL_W-1:0] ld_col_reg;
    logic [ROW_W-1:0] em_row_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic [COLS-1:0]  flags_reg;
    logic [COLS-1:0]  pha_reg;
    logic [COLS-1:0]  phb_reg;
    logic             last_row_reg;

    logic             first_cell;
    logic [COLS-1:0][VW-1:0] diff;
    logic [COLS-1:0]  flags;
    logic [COLS-1:0]  even_mask;
    logic [COLS-1:0]  no_underflow;

    assign first_cell       = (ld_row_reg == '0) && (ld_col_reg == '0);
    assign status.last_cell = (ld_row_reg == ROW_LAST) && (ld_col_reg == COL_LAST);
    assign status.last_emit = (em_row_reg == ROW_LAST);

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= cbf_pkg::THRESHOLD_RESET;
        else if (cfg_wr)
            thr_reg <= cfg_data;
    end

    // Cell store write and row read
    always_ff @(posedge clk)
    begin
        if (cmd.cell_wr)
            cell_mem[ld_row_reg][ld_col_reg] <= cell_voltage_mv;
        if (cmd.rd_en)
            rd_data_reg <= cell_mem[em_row_reg];
    end

    // Load position and running minimum; first cell of a pack always replaces
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_row_reg  <= '0;
            ld_col_reg  <= '0;
            min_reg     <= '0;
            min_row_reg <= '0;
            min_col_reg <= '0;
        end
        else if (cmd.cell_wr)
        begin
            if (first_cell || (cell_voltage_mv < min_reg))
            begin
                min_reg     <= cell_voltage_mv;
                min_row_reg <= ld_row_reg;
                min_col_reg <= ld_col_reg;
            end
            if (ld_col_reg == COL_LAST)
            begin
                ld_col_reg <= '0;
                ld_row_reg <= (ld_row_reg == ROW_LAST) ? '0 : ld_row_reg + 1'b1;
            end
            else
            begin
                ld_col_reg <= ld_col_reg + 1'b1;
            end
        end
    end

    // Emit row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            em_row_reg <= '0;
        else if (cmd.out_adv)
            em_row_reg <= status.last_emit ? '0 : em_row_reg + 1'b1;
    end

    // Per-lane flag compare; checkerboard parity of row plus column
    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            diff[c]         = rd_data_reg[c] - min_reg;
            flags[c]        = (diff[c] >= thr_reg);
            even_mask[c]    = ~(em_row_reg[0] ^ 1'(c));
            no_underflow[c] = (rd_data_reg[c] >= min_reg);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row_reg  <= em_row_reg;
            flags_reg    <= flags;
            pha_reg      <= flags & even_mask;
            phb_reg      <= flags & ~even_mask;
            last_row_reg <= status.last_emit;
        end
    end

    assign row_index       = 4'(out_row_reg);
    assign discharge_flags = 8'(flags_reg);
    assign phase_a_flags   = 8'(pha_reg);
    assign phase_b_flags   = 8'(phb_reg);
    assign min_voltage_mv  = min_reg;
    assign min_row         = 4'(min_row_reg);
    assign min_col         = 3'(min_col_reg);
    assign last_row        = last_row_reg;

    // Load position wraps to the first cell after the pack completes
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cell_wr && status.last_cell) |=> ((ld_row_reg == '0) && (ld_col_reg == '0)))
        else $error("cbf_datapath: load position did not wrap");

    // Every stored cell of a row is at or above the pack minimum
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (no_underflow == '1))
        else $error("cbf_datapath: cell below pack minimum");

    // Phases split the flags without overlap
    a_phase_split: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.out_load) |-> (((pha_reg & phb_reg) == '0) && ((pha_reg | phb_reg) == flags_reg)))
        else $error("cbf_datapath: phase masks inconsistent");

endmodule

`default_nettype wire

// File: hdl/cell_balance_flag_engine.sv
// Top level of the cell balance flag engine: controller, datapath and channel hookup.
//
//   channel  | dir | beat carries                                   | handshake
//   ---------+-----+------------------------------------------------+-------------
//   cell_in  | in  | cell_voltage_mv                                | valid/ready
//   row_out  | out | row_index, flags, phases, min voltage/row/col  | valid/ready
//   cfg      | in  | data (balance_threshold_mv)                    | valid/ready
//
// Cells are taken one per cycle while collecting; the cell store takes one lane write a cycle.
// After the last cell, each row goes through a store read, a compare and a result beat; the
// result beat waits while row_out.ready is low. cell_in.ready is low during emission.
// cfg is always ready; the user must see cfg written only while idle, unchecked by the block.
// rst_n is asynchronous active low; the threshold resets to 50 mV, the cell store is not cleared.
`default_nettype none

module cell_balance_flag_engine (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbf_cell_if.sink    cell_in,
    cbf_row_if.source   row_out,
    cbf_cfg_if.sink     cfg
);

    cbf_pkg::cbf_cmd_t    cmd;
    cbf_pkg::cbf_status_t status;
    logic                 in_ready;
    logic                 out_valid;

    assign cell_in.ready = in_ready;
    assign row_out.valid = out_valid;
    assign cfg.ready     = 1'b1;

    cbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_in.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (row_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cbf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr          (cfg.valid),
        .cfg_data        (cfg.data),
        .cell_voltage_mv (cell_in.cell_voltage_mv),
        .row_index       (row_out.row_index),
        .discharge_flags (row_out.discharge_flags),
        .phase_a_flags   (row_out.phase_a_flags),
        .phase_b_flags   (row_out.phase_b_flags),
        .min_voltage_mv  (row_out.min_voltage_mv),
        .min_row         (row_out.min_row),
        .min_col         (row_out.min_col),
        .last_row        (row_out.last_row)
    );

endmodule

`default_nettype wire
